/* src/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// a holds in the same cycle as b
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a holds, then b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

/* src/cvsr_pkg.sv */
package cvsr_pkg;

    localparam int SUM_W   = 28;
    localparam int CNT_W   = 12;
    localparam int SEEN_W  = 13;
    localparam int WORD_W  = SUM_W + CNT_W;
    localparam int RAW_W   = 32;
    localparam int TOT_W   = 38;
    localparam int SCORE_W = 16;
    localparam int NUM_W   = RAW_W + SCORE_W;
    localparam int MAX_OUT = 16;
    localparam int WGT_W   = 16;
    localparam int LIM_W   = 12;

    typedef logic [1:0] cfg_addr_t;
    typedef logic [LIM_W-1:0] cfg_data_t;

    localparam cfg_addr_t REG_CRITERION = 2'd0;
    localparam cfg_addr_t REG_LIMIT     = 2'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load_cap;
        logic load_wr;
        logic walk_init;
        logic walk_rd;
        logic walk_div;
        logic walk_acc;
        logic norm_div;
        logic norm_wr;
        logic rank_init;
        logic scan_init;
        logic scan_step;
        logic scan_end;
        logic emit;
    } cvsr_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic load_hit;
        logic div_done;
        logic lvl_last;
        logic cls_last;
        logic tot_zero;
        logic k_last;
        logic out_free;
    } cvsr_stat_t;

endpackage

/* src/cvsr_in_if.sv */
interface cvsr_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [2:0]  evidence_level;
    logic [3:0]  class_label;
    logic [15:0] weight_zero;
    logic [15:0] weight_one;
    logic [15:0] weight_two;
    logic [15:0] weight_three;

    modport source (output valid, command, evidence_level, class_label, weight_zero,
                    weight_one, weight_two, weight_three, input ready);
    modport sink (input valid, command, evidence_level, class_label, weight_zero,
                  weight_one, weight_two, weight_three, output ready);
endinterface

/* src/cvsr_out_if.sv */
interface cvsr_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  rank_position;
    logic [3:0]  ranked_class;
    logic [15:0] class_score;
    logic        final_flag;

    modport source (output valid, rank_position, ranked_class, class_score, final_flag,
                    input ready);
    modport sink (input valid, rank_position, ranked_class, class_score, final_flag,
                  output ready);
endinterface

/* src/cvsr_ram.sv */
module cvsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/cvsr_div.sv */
// Restoring divider, one quotient bit per cycle.
module cvsr_div #(
    parameter int NW = 48,
    parameter int DW = 38
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW);

    logic [DW:0]   rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DW-1:0], quo_reg[NW-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

/* src/cvsr_ctrl.sv */
module cvsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    output cvsr_pkg::cvsr_cmd_t cmd,
    input  cvsr_pkg::cvsr_stat_t stat
);
    import cvsr_pkg::*;

    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LD_WR    = 4'd2;
    localparam logic [3:0] S_WK_RD    = 4'd3;
    localparam logic [3:0] S_WK_DIV   = 4'd4;
    localparam logic [3:0] S_WK_WAIT  = 4'd5;
    localparam logic [3:0] S_NM_RD    = 4'd6;
    localparam logic [3:0] S_NM_DIV   = 4'd7;
    localparam logic [3:0] S_NM_WAIT  = 4'd8;
    localparam logic [3:0] S_SCAN     = 4'd9;
    localparam logic [3:0] S_SCAN_END = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_command == CMD_SCORE)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_WK_RD;
                    end
                    else
                    begin
                        cmd.load_cap = 1'b1;
                        if (stat.load_hit)
                        begin
                            state_next = S_LD_WR;
                        end
                    end
                end
            end
            S_LD_WR:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_WK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WK_DIV;
            end
            S_WK_DIV:
            begin
                cmd.walk_div = 1'b1;
                state_next   = S_WK_WAIT;
            end
            S_WK_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.walk_acc = 1'b1;
                    state_next = (stat.lvl_last && stat.cls_last) ? S_NM_RD : S_WK_RD;
                end
            end
            S_NM_RD:
            begin
                state_next = S_NM_DIV;
            end
            S_NM_DIV:
            begin
                cmd.norm_div = 1'b1;
                if (!stat.tot_zero)
                begin
                    state_next = S_NM_WAIT;
                end
                else if (stat.cls_last)
                begin
                    cmd.rank_init = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_NM_RD;
                end
            end
            S_NM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.norm_wr = 1'b1;
                    if (stat.cls_last)
                    begin
                        cmd.rank_init = 1'b1;
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_NM_RD;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.cls_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                cmd.scan_end = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.k_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* src/cvsr_dp.sv */
module cvsr_dp #(
    parameter int NUM_CLASSES         = 16,
    parameter int NUM_EVIDENCE_LEVELS = 8,
    parameter int NUM_CRITERIA        = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cvsr_pkg::cvsr_cmd_t  cmd,
    output cvsr_pkg::cvsr_stat_t stat,
    input  logic                 cfg_we,
    input  cvsr_pkg::cfg_addr_t  cfg_addr,
    input  cvsr_pkg::cfg_data_t  cfg_data,
    input  logic [2:0]           evidence_level,
    input  logic [3:0]           class_label,
    input  logic [15:0]          weight_zero,
    input  logic [15:0]          weight_one,
    input  logic [15:0]          weight_two,
    input  logic [15:0]          weight_three,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           rank_position,
    output logic [3:0]           ranked_class,
    output logic [15:0]          class_score,
    output logic                 final_flag
);
    import cvsr_pkg::*;

    localparam int DEPTH = NUM_CLASSES * NUM_EVIDENCE_LEVELS;
    localparam int SAW   = $clog2(DEPTH);
    localparam int CW    = $clog2(NUM_CLASSES);
    localparam int LW    = $clog2(NUM_EVIDENCE_LEVELS);
    localparam int N_OUT = (NUM_CLASSES < MAX_OUT) ? NUM_CLASSES : MAX_OUT;

    // configuration
    logic [1:0]       crit_reg;
    logic [LIM_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_reg  <= '0;
            limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CRITERION: crit_reg  <= cfg_data[1:0];
                REG_LIMIT:     limit_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // counters and accumulators
    logic [SAW-1:0]    clr_cnt_reg;
    logic [CW-1:0]     cls_reg;
    logic [LW-1:0]     lvl_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [RAW_W-1:0]  acc_reg;
    logic [TOT_W-1:0]  tot_reg;
    logic [3:0]        k_reg;
    logic [NUM_CLASSES-1:0] used_reg;
    logic              pend_vld_reg;
    logic [CW-1:0]     pend_idx_reg;
    logic              best_vld_reg;
    logic [CW-1:0]     best_idx_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic              out_valid_reg;
    logic [SAW-1:0]    ld_addr_reg;
    logic [WGT_W-1:0]  ld_w_reg;

    // load decode
    logic [1:0]       crit_mod;
    logic [WGT_W-1:0] w_sel;
    logic [SAW-1:0]   ld_addr;
    logic [SAW-1:0]   walk_addr;

    always_comb
    begin
        if (NUM_CRITERIA == 1)
        begin
            crit_mod = 2'd0;
        end
        else if (32'(crit_reg) >= NUM_CRITERIA)
        begin
            crit_mod = 2'(32'(crit_reg) - NUM_CRITERIA);
        end
        else
        begin
            crit_mod = crit_reg;
        end
        case (crit_mod)
            2'd0:    w_sel = weight_zero;
            2'd1:    w_sel = weight_one;
            2'd2:    w_sel = weight_two;
            default: w_sel = weight_three;
        endcase
    end

    assign ld_addr   = SAW'(32'(evidence_level) * NUM_CLASSES + 32'(class_label));
    assign walk_addr = SAW'(32'(lvl_reg) * NUM_CLASSES + 32'(cls_reg));

    assign stat.load_hit = (seen_reg < {1'b0, limit_reg}) && (evidence_level != 3'd0)
                         && (32'(evidence_level) < NUM_EVIDENCE_LEVELS)
                         && (32'(class_label) < NUM_CLASSES);

    // store memory: {count, sum}
    logic              st_we;
    logic [SAW-1:0]    st_waddr;
    logic [WORD_W-1:0] st_wdata;
    logic [WORD_W-1:0] st_rdata;
    logic [SUM_W-1:0]  st_sum;
    logic [CNT_W-1:0]  st_cnt;

    assign st_sum = st_rdata[SUM_W-1:0];
    assign st_cnt = st_rdata[WORD_W-1:SUM_W];

    always_comb
    begin
        st_we    = cmd.clr_step | cmd.load_wr | cmd.walk_div;
        st_waddr = walk_addr;
        st_wdata = '0;
        if (cmd.clr_step)
        begin
            st_waddr = clr_cnt_reg;
        end
        else if (cmd.load_wr)
        begin
            st_waddr = ld_addr_reg;
            st_wdata = {(st_cnt == '1) ? st_cnt : st_cnt + 1'b1,
                        st_sum + SUM_W'(ld_w_reg)};
        end
    end

    cvsr_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (cmd.load_cap ? ld_addr : walk_addr),
        .rdata (st_rdata)
    );

    // per-class memory: raw score, then normalized score
    logic              cr_we;
    logic [RAW_W-1:0]  cr_wdata;
    logic [RAW_W-1:0]  cr_rdata;
    logic [RAW_W-1:0]  acc_sum;
    logic [NUM_W-1:0]  div_num;
    logic [TOT_W-1:0]  div_den;
    logic [NUM_W-1:0]  div_quo;
    logic              div_done;
    logic [SCORE_W-1:0] score_sat;

    assign acc_sum   = acc_reg + div_quo[RAW_W-1:0];
    assign score_sat = (div_quo > NUM_W'(16'hFFFF)) ? '1 : div_quo[SCORE_W-1:0];

    always_comb
    begin
        cr_we    = (cmd.walk_acc && stat.lvl_last) || (cmd.norm_div && stat.tot_zero)
                 || cmd.norm_wr;
        cr_wdata = '0;
        if (cmd.walk_acc)
        begin
            cr_wdata = acc_sum;
        end
        else if (cmd.norm_wr)
        begin
            cr_wdata = RAW_W'(score_sat);
        end
    end

    cvsr_ram #(.WIDTH(RAW_W), .DEPTH(NUM_CLASSES)) u_class (
        .clk   (clk),
        .we    (cr_we),
        .waddr (cls_reg),
        .wdata (cr_wdata),
        .raddr (cls_reg),
        .rdata (cr_rdata)
    );

    assign div_num = cmd.walk_div ? NUM_W'(st_sum) : {cr_rdata, {SCORE_W{1'b0}}};
    assign div_den = cmd.walk_div ? TOT_W'({1'b0, st_cnt} + 1'b1) : tot_reg;

    cvsr_div #(.NW(NUM_W), .DW(TOT_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.walk_div || (cmd.norm_div && !stat.tot_zero)),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // status
    assign stat.clr_last = (clr_cnt_reg == SAW'(DEPTH - 1));
    assign stat.div_done = div_done;
    assign stat.lvl_last = (lvl_reg == LW'(NUM_EVIDENCE_LEVELS - 1));
    assign stat.cls_last = (cls_reg == CW'(NUM_CLASSES - 1));
    assign stat.tot_zero = (tot_reg == '0);
    assign stat.k_last   = (k_reg == 4'(N_OUT - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    logic          cmp_en;
    logic          take;
    logic          cls_adv;

    assign cmp_en  = (cmd.scan_step || cmd.scan_end) && pend_vld_reg;
    assign take    = cmp_en && !used_reg[pend_idx_reg]
                   && (!best_vld_reg || cr_rdata[SCORE_W-1:0] > best_score_reg);
    assign cls_adv = (cmd.walk_acc && stat.lvl_last) || (cmd.norm_div && stat.tot_zero)
                   || cmd.norm_wr || cmd.scan_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            cls_reg       <= '0;
            lvl_reg       <= LW'(1);
            seen_reg      <= '0;
            acc_reg       <= '0;
            tot_reg       <= '0;
            k_reg         <= '0;
            used_reg      <= '0;
            pend_vld_reg  <= 1'b0;
            best_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= stat.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
            if (cmd.load_cap && seen_reg != '1)
            begin
                seen_reg <= seen_reg + 1'b1;
            end
            if (cmd.walk_init)
            begin
                seen_reg <= '0;
                cls_reg  <= '0;
                lvl_reg  <= LW'(1);
                acc_reg  <= '0;
                tot_reg  <= '0;
            end
            if (cmd.walk_acc)
            begin
                if (stat.lvl_last)
                begin
                    lvl_reg <= LW'(1);
                    acc_reg <= '0;
                    tot_reg <= tot_reg + TOT_W'(acc_sum);
                end
                else
                begin
                    lvl_reg <= lvl_reg + 1'b1;
                    acc_reg <= acc_sum;
                end
            end
            if (cls_adv)
            begin
                cls_reg <= stat.cls_last ? '0 : cls_reg + 1'b1;
            end
            if (cmd.rank_init)
            begin
                k_reg    <= '0;
                used_reg <= '0;
            end
            pend_vld_reg <= cmd.scan_step;
            if (cmd.scan_init)
            begin
                best_vld_reg <= 1'b0;
            end
            else if (take)
            begin
                best_vld_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                used_reg[best_idx_reg] <= 1'b1;
                k_reg <= k_reg + 1'b1;
            end
            out_valid_reg <= cmd.emit || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cap)
        begin
            ld_addr_reg <= ld_addr;
            ld_w_reg    <= w_sel;
        end
        if (cmd.scan_step)
        begin
            pend_idx_reg <= cls_reg;
        end
        if (take)
        begin
            best_idx_reg   <= pend_idx_reg;
            best_score_reg <= cr_rdata[SCORE_W-1:0];
        end
        if (cmd.emit)
        begin
            rank_position <= k_reg;
            ranked_class  <= 4'(best_idx_reg);
            class_score   <= best_score_reg;
            final_flag    <= stat.k_last;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

/* src/class_vote_score_ranker_core.sv */
// Load beat: a dropped rule takes only the capture state; one that counts reads, then writes the cell.
// Score beat: one serial divide per store cell of levels 1..L-1 and per class with a nonzero
//   total, then a ranking pass over all classes per emitted beat; all divides share one
//   serial divider. No input is taken until the last beat is loaded.
// Reset: the reset registers clear at once, then a pass over all NUM_CLASSES*NUM_EVIDENCE_LEVELS
//   cells zeroes the store; config writes are taken during it.
`include "assert_macros.svh"

module class_vote_score_ranker_core #(
    parameter int NUM_CLASSES         = 16,
    parameter int NUM_EVIDENCE_LEVELS = 8,
    parameter int NUM_CRITERIA        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    cvsr_in_if.sink             in_ch,
    cvsr_out_if.source          out_ch,
    input  logic                cfg_we,
    input  cvsr_pkg::cfg_addr_t cfg_addr,
    input  cvsr_pkg::cfg_data_t cfg_data
);
    import cvsr_pkg::*;

    localparam int N_OUT = (NUM_CLASSES < MAX_OUT) ? NUM_CLASSES : MAX_OUT;

    cvsr_cmd_t  cmd;
    cvsr_stat_t stat;

    // Sequencer: clear pass, load read-modify-write, walk, normalize, rank.
    cvsr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Store, class scores, shared divider and output beat register.
    cvsr_dp #(
        .NUM_CLASSES         (NUM_CLASSES),
        .NUM_EVIDENCE_LEVELS (NUM_EVIDENCE_LEVELS),
        .NUM_CRITERIA        (NUM_CRITERIA)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .evidence_level (in_ch.evidence_level),
        .class_label    (in_ch.class_label),
        .weight_zero    (in_ch.weight_zero),
        .weight_one     (in_ch.weight_one),
        .weight_two     (in_ch.weight_two),
        .weight_three   (in_ch.weight_three),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .rank_position  (out_ch.rank_position),
        .ranked_class   (out_ch.ranked_class),
        .class_score    (out_ch.class_score),
        .final_flag     (out_ch.final_flag)
    );

    // a score beat always starts the walk, so input closes
    `ASSERT_NEXT(a_score_busy, clk, rst_n,
        in_ch.valid && in_ch.ready && in_ch.command == CMD_SCORE, !in_ch.ready)
    // while a ranking is still being emitted no beat is taken
    `ASSERT_SAME(a_rank_blocks, clk, rst_n,
        out_ch.valid && !out_ch.final_flag, !in_ch.ready)
    // the last beat sits at the last rank position
    `ASSERT_SAME(a_final_pos, clk, rst_n,
        out_ch.valid && out_ch.final_flag, out_ch.rank_position == 4'(N_OUT - 1))
endmodule
